>>> hw/rtl/jfcd_pkg.sv
// shared types, command codes and constants of the flash command decoder
package jfcd_pkg;

    localparam int ADDR_W     = 18;
    localparam int DATA_W     = 8;
    localparam int CMD_ADDR_W = 15;
    localparam int CFG_IDX_W  = 1;

    // command addresses, compared on the low address bits only
    localparam logic [CMD_ADDR_W-1:0] ADDR_A = 15'h5555;
    localparam logic [CMD_ADDR_W-1:0] ADDR_B = 15'h2AAA;

    // command bytes
    localparam logic [DATA_W-1:0] BYTE_UNLOCK1     = 8'hAA;
    localparam logic [DATA_W-1:0] BYTE_UNLOCK2     = 8'h55;
    localparam logic [DATA_W-1:0] BYTE_ID_ENTRY    = 8'h90;
    localparam logic [DATA_W-1:0] BYTE_ID_EXIT     = 8'hF0;
    localparam logic [DATA_W-1:0] BYTE_PROGRAM     = 8'hA0;
    localparam logic [DATA_W-1:0] BYTE_ERASE_SETUP = 8'h80;
    localparam logic [DATA_W-1:0] BYTE_CHIP_ERASE  = 8'h10;
    localparam logic [DATA_W-1:0] BYTE_ERASED      = 8'hFF;

    // configuration registers
    localparam logic [CFG_IDX_W-1:0] CFG_MANUFACTURER_ID = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID       = 1'b1;
    localparam logic [DATA_W-1:0]    MANUFACTURER_ID_RST = 8'hBF;
    localparam logic [DATA_W-1:0]    DEVICE_ID_RST       = 8'hB6;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] data;
    } in_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              in_id_mode;
    } out_item_t;

    typedef enum logic [2:0] {
        CODE_UNLOCK1,
        CODE_UNLOCK2,
        CODE_ID_ENTRY,
        CODE_ID_EXIT,
        CODE_PROGRAM,
        CODE_ERASE_SETUP,
        CODE_CHIP_ERASE,
        CODE_OTHER
    } code_t;

    // classified request handed from front to back
    typedef struct packed {
        logic              is_write;
        logic              at_a;
        logic              at_b;
        code_t             code;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] data;
    } cmd_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_U1,
        SEQ_U2,
        SEQ_PROG,
        SEQ_E80,
        SEQ_E1,
        SEQ_E2
    } seq_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_RUN,
        BK_READ,
        BK_PROG
    } back_state_t;

    function automatic code_t classify_byte(input logic [DATA_W-1:0] b);
        code_t c;
        unique case (b)
            BYTE_UNLOCK1:     c = CODE_UNLOCK1;
            BYTE_UNLOCK2:     c = CODE_UNLOCK2;
            BYTE_ID_ENTRY:    c = CODE_ID_ENTRY;
            BYTE_ID_EXIT:     c = CODE_ID_EXIT;
            BYTE_PROGRAM:     c = CODE_PROGRAM;
            BYTE_ERASE_SETUP: c = CODE_ERASE_SETUP;
            BYTE_CHIP_ERASE:  c = CODE_CHIP_ERASE;
            default:          c = CODE_OTHER;
        endcase
        return c;
    endfunction

endpackage

>>> hw/rtl/jedec_flash_command_decoder.sv
// top level of the flash command decoder: ports, id registers, front and back
//
//  channel   ports                        handshake
//  request   request (in_item_t)          accepted when push && !full
//  result    result (out_item_t)          accepted when pop && !empty
//  config    cfg_write, cfg_index, cfg_data  written when cfg_write
//
// in the back end a read is one array read, then a result from the registered data,
// an id-mode read or a command write gives its result as it is taken, and a program
// write is a read, then an and-in write on the single array port
// after reset and after each chip erase the array is swept to 0xff, one byte
// a cycle over all 2**ADDR_BITS bytes, and full stays high for the whole sweep
// a two-entry queue on each side lets push continue while pop stalls until
// both queues fill

module jedec_flash_command_decoder #(
    parameter int ADDR_BITS = 18
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // request side
    input  logic                             push,
    input  jfcd_pkg::in_item_t               request,
    output logic                             full,
    // result side
    input  logic                             pop,
    output logic                             empty,
    output jfcd_pkg::out_item_t              result,
    // configuration
    input  logic                             cfg_write,
    input  logic [jfcd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [jfcd_pkg::DATA_W-1:0]      cfg_data
);

    // identification bytes
    logic [jfcd_pkg::DATA_W-1:0] manufacturer_id_reg;
    logic [jfcd_pkg::DATA_W-1:0] manufacturer_id_next;
    logic [jfcd_pkg::DATA_W-1:0] device_id_reg;
    logic [jfcd_pkg::DATA_W-1:0] device_id_next;

    // front to back
    logic                        cmd_valid;
    logic                        cmd_ready;
    jfcd_pkg::cmd_t              cmd;
    jfcd_pkg::back_status_t      status;

    // register write decode
    always_comb
    begin
        manufacturer_id_next = manufacturer_id_reg;
        device_id_next       = device_id_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                jfcd_pkg::CFG_MANUFACTURER_ID: manufacturer_id_next = cfg_data;
                jfcd_pkg::CFG_DEVICE_ID:       device_id_next       = cfg_data;
                default:                       device_id_next       = device_id_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            manufacturer_id_reg <= jfcd_pkg::MANUFACTURER_ID_RST;
            device_id_reg       <= jfcd_pkg::DEVICE_ID_RST;
        end
        else
        begin
            manufacturer_id_reg <= manufacturer_id_next;
            device_id_reg       <= device_id_next;
        end
    end

    // front: request intake and command classification
    jfcd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .request  (request),
        .full     (full),
        .status   (status),
        .cmd_ready(cmd_ready),
        .cmd_valid(cmd_valid),
        .cmd      (cmd)
    );

    // back: sequencer, array and result queue
    jfcd_back #(
        .ADDR_BITS(ADDR_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd),
        .cmd_ready      (cmd_ready),
        .status         (status),
        .manufacturer_id(manufacturer_id_reg),
        .device_id      (device_id_reg),
        .pop            (pop),
        .empty          (empty),
        .result         (result)
    );

endmodule

>>> hw/rtl/jfcd_ram.sv
// generic single-port ram with registered read
module jfcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 262144
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/jfcd_fifo.sv
// two-entry queue
module jfcd_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             full,
    output logic             empty
);

    logic [WIDTH-1:0] data_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = data_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

>>> hw/rtl/jfcd_front.sv
// front end: takes requests, decodes command address and byte, queues them
module jfcd_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  jfcd_pkg::in_item_t    request,
    output logic                  full,
    input  jfcd_pkg::back_status_t status,
    input  logic                  cmd_ready,
    output logic                  cmd_valid,
    output jfcd_pkg::cmd_t        cmd
);

    jfcd_pkg::cmd_t               classified;
    logic [$bits(jfcd_pkg::cmd_t)-1:0] q_dout;
    logic                         q_full;
    logic                         q_empty;

    always_comb
    begin
        classified.is_write = (request.op == jfcd_pkg::OP_WRITE);
        classified.at_a     = (request.address[jfcd_pkg::CMD_ADDR_W-1:0] == jfcd_pkg::ADDR_A);
        classified.at_b     = (request.address[jfcd_pkg::CMD_ADDR_W-1:0] == jfcd_pkg::ADDR_B);
        classified.code     = jfcd_pkg::classify_byte(request.data);
        classified.address  = request.address;
        classified.data     = request.data;
    end

    // no requests taken while the array is being swept
    assign full = q_full || status.clearing;

    jfcd_fifo #(
        .WIDTH($bits(jfcd_pkg::cmd_t))
    ) u_cmd_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (push && !full),
        .din  (classified),
        .pop  (cmd_ready),
        .dout (q_dout),
        .full (q_full),
        .empty(q_empty)
    );

    assign cmd_valid = !q_empty;
    assign cmd       = jfcd_pkg::cmd_t'(q_dout);

endmodule

>>> hw/rtl/jfcd_back.sv
// back end: command sequencer, array access, erase sweep and result queue
module jfcd_back #(
    parameter int ADDR_BITS = 18
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    input  jfcd_pkg::cmd_t                 cmd,
    output logic                           cmd_ready,
    output jfcd_pkg::back_status_t         status,
    input  logic [jfcd_pkg::DATA_W-1:0]    manufacturer_id,
    input  logic [jfcd_pkg::DATA_W-1:0]    device_id,
    input  logic                           pop,
    output logic                           empty,
    output jfcd_pkg::out_item_t            result
);

    localparam int DEPTH = 1 << ADDR_BITS;

    jfcd_pkg::back_state_t            state_reg;
    jfcd_pkg::back_state_t            state_next;
    jfcd_pkg::seq_t                   seq_reg;
    jfcd_pkg::seq_t                   seq_next;
    logic                             id_reg;
    logic                             id_next;
    logic [ADDR_BITS-1:0]             ptr_reg;
    logic [ADDR_BITS-1:0]             ptr_next;
    logic [ADDR_BITS-1:0]             pend_addr_reg;
    logic [ADDR_BITS-1:0]             pend_addr_next;
    logic [jfcd_pkg::DATA_W-1:0]      pend_data_reg;
    logic [jfcd_pkg::DATA_W-1:0]      pend_data_next;

    logic                             ram_we;
    logic [ADDR_BITS-1:0]             ram_addr;
    logic [jfcd_pkg::DATA_W-1:0]      ram_wdata;
    logic [jfcd_pkg::DATA_W-1:0]      ram_rdata;

    logic                             res_push;
    jfcd_pkg::out_item_t              res_item;
    logic                             res_full;
    logic [$bits(jfcd_pkg::out_item_t)-1:0] res_dout;
    logic [ADDR_BITS-1:0]             cmd_addr;
    logic                             take;

    assign cmd_addr = ADDR_BITS'(cmd.address);

    always_comb
    begin
        state_next     = state_reg;
        seq_next       = seq_reg;
        id_next        = id_reg;
        ptr_next       = ptr_reg;
        pend_addr_next = pend_addr_reg;
        pend_data_next = pend_data_reg;
        ram_we         = 1'b0;
        ram_addr       = cmd_addr;
        ram_wdata      = jfcd_pkg::BYTE_ERASED;
        res_push       = 1'b0;
        res_item       = '0;
        cmd_ready      = 1'b0;
        take           = 1'b0;

        unique case (state_reg)
            jfcd_pkg::BK_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = ptr_reg;
                ram_wdata = jfcd_pkg::BYTE_ERASED;
                ptr_next  = ptr_reg + ADDR_BITS'(1);
                if (ptr_reg == '1)
                begin
                    state_next = jfcd_pkg::BK_RUN;
                end
            end

            jfcd_pkg::BK_RUN:
            begin
                cmd_ready = !res_full;
                take      = cmd_valid && !res_full;
                if (take && !cmd.is_write)
                begin
                    if (id_reg)
                    begin
                        res_push = 1'b1;
                        res_item.read_data  = cmd.address[0] ? device_id : manufacturer_id;
                        res_item.in_id_mode = id_reg;
                    end
                    else
                    begin
                        state_next = jfcd_pkg::BK_READ;
                    end
                end
                else if (take)
                begin
                    seq_next = jfcd_pkg::SEQ_IDLE;
                    unique case (seq_reg)
                        jfcd_pkg::SEQ_IDLE:
                        begin
                            if (cmd.at_a && cmd.code == jfcd_pkg::CODE_UNLOCK1)
                            begin
                                seq_next = jfcd_pkg::SEQ_U1;
                            end
                            else if (cmd.code == jfcd_pkg::CODE_ID_EXIT)
                            begin
                                id_next = 1'b0;
                            end
                        end
                        jfcd_pkg::SEQ_U1:
                        begin
                            if (cmd.at_b && cmd.code == jfcd_pkg::CODE_UNLOCK2)
                            begin
                                seq_next = jfcd_pkg::SEQ_U2;
                            end
                        end
                        jfcd_pkg::SEQ_U2:
                        begin
                            if (cmd.at_a)
                            begin
                                unique case (cmd.code)
                                    jfcd_pkg::CODE_ID_ENTRY:    id_next  = 1'b1;
                                    jfcd_pkg::CODE_ID_EXIT:     id_next  = 1'b0;
                                    jfcd_pkg::CODE_PROGRAM:     seq_next = jfcd_pkg::SEQ_PROG;
                                    jfcd_pkg::CODE_ERASE_SETUP: seq_next = jfcd_pkg::SEQ_E80;
                                    default:                    seq_next = jfcd_pkg::SEQ_IDLE;
                                endcase
                            end
                        end
                        jfcd_pkg::SEQ_PROG:
                        begin
                            // fetch the cell, and it in on the next cycle
                            pend_addr_next = cmd_addr;
                            pend_data_next = cmd.data;
                            state_next     = jfcd_pkg::BK_PROG;
                        end
                        jfcd_pkg::SEQ_E80:
                        begin
                            if (cmd.at_a && cmd.code == jfcd_pkg::CODE_UNLOCK1)
                            begin
                                seq_next = jfcd_pkg::SEQ_E1;
                            end
                        end
                        jfcd_pkg::SEQ_E1:
                        begin
                            if (cmd.at_b && cmd.code == jfcd_pkg::CODE_UNLOCK2)
                            begin
                                seq_next = jfcd_pkg::SEQ_E2;
                            end
                        end
                        jfcd_pkg::SEQ_E2:
                        begin
                            if (cmd.at_a && cmd.code == jfcd_pkg::CODE_CHIP_ERASE)
                            begin
                                state_next = jfcd_pkg::BK_CLEAR;
                            end
                        end
                        default:
                        begin
                            seq_next = jfcd_pkg::SEQ_IDLE;
                        end
                    endcase
                    if (seq_reg != jfcd_pkg::SEQ_PROG)
                    begin
                        res_push            = 1'b1;
                        res_item.read_data  = '0;
                        res_item.in_id_mode = id_next;
                    end
                end
            end

            jfcd_pkg::BK_READ:
            begin
                res_push            = 1'b1;
                res_item.read_data  = ram_rdata;
                res_item.in_id_mode = id_reg;
                state_next          = jfcd_pkg::BK_RUN;
            end

            jfcd_pkg::BK_PROG:
            begin
                ram_we              = 1'b1;
                ram_addr            = pend_addr_reg;
                ram_wdata           = ram_rdata & pend_data_reg;
                res_push            = 1'b1;
                res_item.read_data  = '0;
                res_item.in_id_mode = id_reg;
                state_next          = jfcd_pkg::BK_RUN;
            end

            default:
            begin
                state_next = jfcd_pkg::BK_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= jfcd_pkg::BK_CLEAR;
            seq_reg   <= jfcd_pkg::SEQ_IDLE;
            id_reg    <= 1'b0;
            ptr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            seq_reg   <= seq_next;
            id_reg    <= id_next;
            ptr_reg   <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        pend_data_reg <= pend_data_next;
    end

    assign status.clearing = (state_reg == jfcd_pkg::BK_CLEAR);

    jfcd_ram #(
        .WIDTH(jfcd_pkg::DATA_W),
        .DEPTH(DEPTH)
    ) u_array (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    jfcd_fifo #(
        .WIDTH($bits(jfcd_pkg::out_item_t))
    ) u_res_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (res_push),
        .din  (res_item),
        .pop  (pop),
        .dout (res_dout),
        .full (res_full),
        .empty(empty)
    );

    assign result = jfcd_pkg::out_item_t'(res_dout);

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into a full queue");

    a_no_take_off_run: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_ready |-> state_reg == jfcd_pkg::BK_RUN)
        else $error("request taken outside run state");

    a_read_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == jfcd_pkg::BK_READ || state_reg == jfcd_pkg::BK_PROG)
        |=> state_reg == jfcd_pkg::BK_RUN)
        else $error("array access did not return to run");

    a_sweep_ends_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(state_reg == jfcd_pkg::BK_CLEAR) |-> ptr_reg == '0)
        else $error("erase sweep ended off zero");

    a_prog_from_sequence: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == jfcd_pkg::BK_PROG |-> $past(seq_reg) == jfcd_pkg::SEQ_PROG)
        else $error("program without armed sequence");

endmodule

>>> tb/sv/tb_jedec_flash_command_decoder.sv
// self-checking testbench of the flash command decoder: directed table, then random bus traffic
module tb_jedec_flash_command_decoder;

    // generous ceiling: three full-array sweeps (reset, two chip erases) plus traffic
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int PRINT_LIMIT  = 100;
    localparam int PHASE_ITEMS  = 425;
    localparam int HOLD_CYCLES  = 150;
    localparam int SETTLE       = 24;

    localparam int AW = jfcd_pkg::ADDR_W;
    localparam int DW = jfcd_pkg::DATA_W;
    localparam int IW = $bits(jfcd_pkg::in_item_t);

    // one row of the directed table; 'typed' rows carry their expectation by hand
    typedef struct {
        jfcd_pkg::in_item_t  req;
        bit                  typed;
        jfcd_pkg::out_item_t want;
    } dir_row_t;

    logic                           clk;
    logic                           rst_n;
    logic                           push;
    jfcd_pkg::in_item_t             request;
    logic                           full;
    logic                           pop;
    logic                           empty;
    jfcd_pkg::out_item_t            result;
    logic                           cfg_write;
    logic [jfcd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [DW-1:0]                  cfg_data;

    jedec_flash_command_decoder uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .request   (request),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // ------------------------------------------------------------------
    // shadow copy of the device: sequencer, id mode, id bytes and cells
    // cells never programmed since the last erase read back as erased
    // ------------------------------------------------------------------
    jfcd_pkg::seq_t       seq_step  = jfcd_pkg::SEQ_IDLE;
    logic                 id_mode   = 1'b0;
    logic [DW-1:0]        mfr_id    = jfcd_pkg::MANUFACTURER_ID_RST;
    logic [DW-1:0]        dev_id    = jfcd_pkg::DEVICE_ID_RST;
    bit   [DW-1:0]        cells [bit [AW-1:0]];

    // results owed by the block, oldest first
    jfcd_pkg::out_item_t  access_results_due [$];

    // run statistics
    int cycle_count       = 0;
    int mismatches        = 0;
    int results_checked   = 0;
    int accesses_in       = 0;
    int reads_in          = 0;
    int writes_in         = 0;
    int programs_seen     = 0;
    int erases_seen       = 0;
    int id_entries        = 0;
    int full_stall_cycles = 0;
    int id_settings       = 1;

    // chip erases allowed: one directed, one random (each costs a full sweep)
    int erases_left       = 2;
    int burst_left        = 0;
    bit hold_off_req      = 1'b0;
    bit hold_off_done     = 1'b0;

    logic [AW-1:0] hot_addr [16];
    dir_row_t      plan [$];

    function automatic logic [DW-1:0] cell_at(input logic [AW-1:0] addr);
        return cells.exists(addr) ? cells[addr] : jfcd_pkg::BYTE_ERASED;
    endfunction

    // advance the shadow device by one bus access and return what it answers
    function automatic jfcd_pkg::out_item_t predict_access(input jfcd_pkg::in_item_t a);
        jfcd_pkg::out_item_t r;
        logic                at_a;
        logic                at_b;
        jfcd_pkg::seq_t      nxt;
        r    = '0;
        at_a = (a.address[jfcd_pkg::CMD_ADDR_W-1:0] == jfcd_pkg::ADDR_A);
        at_b = (a.address[jfcd_pkg::CMD_ADDR_W-1:0] == jfcd_pkg::ADDR_B);
        nxt  = jfcd_pkg::SEQ_IDLE;
        if (a.op == jfcd_pkg::OP_READ)
        begin
            // reads never move the sequencer
            if (id_mode)
                r.read_data = a.address[0] ? dev_id : mfr_id;
            else
                r.read_data = cell_at(a.address);
        end
        else
        begin
            case (seq_step)
                jfcd_pkg::SEQ_IDLE:
                begin
                    if (at_a && a.data == jfcd_pkg::BYTE_UNLOCK1)
                        nxt = jfcd_pkg::SEQ_U1;
                    else if (a.data == jfcd_pkg::BYTE_ID_EXIT)
                        id_mode = 1'b0;   // short id exit, any address
                end
                jfcd_pkg::SEQ_U1:
                    if (at_b && a.data == jfcd_pkg::BYTE_UNLOCK2)
                        nxt = jfcd_pkg::SEQ_U2;
                jfcd_pkg::SEQ_U2:
                begin
                    if (at_a)
                    begin
                        if (a.data == jfcd_pkg::BYTE_ID_ENTRY)
                        begin
                            id_mode = 1'b1;
                            id_entries++;
                        end
                        else if (a.data == jfcd_pkg::BYTE_ID_EXIT)
                            id_mode = 1'b0;
                        else if (a.data == jfcd_pkg::BYTE_PROGRAM)
                            nxt = jfcd_pkg::SEQ_PROG;
                        else if (a.data == jfcd_pkg::BYTE_ERASE_SETUP)
                            nxt = jfcd_pkg::SEQ_E80;
                    end
                end
                jfcd_pkg::SEQ_PROG:
                begin
                    // programming can only clear bits
                    cells[a.address] = cell_at(a.address) & a.data;
                    programs_seen++;
                end
                jfcd_pkg::SEQ_E80:
                    if (at_a && a.data == jfcd_pkg::BYTE_UNLOCK1)
                        nxt = jfcd_pkg::SEQ_E1;
                jfcd_pkg::SEQ_E1:
                    if (at_b && a.data == jfcd_pkg::BYTE_UNLOCK2)
                        nxt = jfcd_pkg::SEQ_E2;
                jfcd_pkg::SEQ_E2:
                begin
                    if (at_a && a.data == jfcd_pkg::BYTE_CHIP_ERASE)
                    begin
                        cells.delete();
                        erases_seen++;
                    end
                end
                default: ;
            endcase
            seq_step = nxt;
        end
        r.in_id_mode = id_mode;
        return r;
    endfunction

    task automatic report(input string what, input int got, input int want);
        if (mismatches < PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
        mismatches++;
    endtask

    // compare one popped result with the oldest owed one
    task automatic check_result(input jfcd_pkg::out_item_t got);
        jfcd_pkg::out_item_t want;
        if (access_results_due.size() == 0)
            report("result with nothing owed, read_data", int'(got.read_data), 0);
        else
        begin
            want = access_results_due.pop_front();
            if (got.read_data !== want.read_data)
                report("read_data", int'(got.read_data), int'(want.read_data));
            if (got.in_id_mode !== want.in_id_mode)
                report("in_id_mode", int'(got.in_id_mode), int'(want.in_id_mode));
            results_checked++;
        end
    endtask

    // ------------------------------------------------------------------
    // request side: bursts of back-to-back requests, random gaps between
    // them with junk on the request bus and push low
    // ------------------------------------------------------------------
    task automatic offer(input jfcd_pkg::in_item_t req_in, input bit typed = 1'b0,
                         input jfcd_pkg::out_item_t want = '0);
        jfcd_pkg::in_item_t  a;
        jfcd_pkg::out_item_t got;
        int                  gap;
        a = req_in;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap)
            begin
                @(negedge clk);
                push    <= 1'b0;
                request <= IW'($urandom);
            end
        end
        burst_left--;
        // keep the number of chip erases (and their long sweeps) bounded
        if (a.op == jfcd_pkg::OP_WRITE && seq_step == jfcd_pkg::SEQ_E2 &&
            a.data == jfcd_pkg::BYTE_CHIP_ERASE &&
            a.address[jfcd_pkg::CMD_ADDR_W-1:0] == jfcd_pkg::ADDR_A)
        begin
            if (erases_left == 0)
                a.data = jfcd_pkg::BYTE_CHIP_ERASE ^ 8'h01;
            else
                erases_left--;
        end
        @(negedge clk);
        push    <= 1'b1;
        request <= a;
        @(posedge clk);
        while (full)
        begin
            full_stall_cycles++;
            @(posedge clk);
        end
        got = predict_access(a);
        access_results_due.push_back(typed ? want : got);
        accesses_in++;
        if (a.op == jfcd_pkg::OP_READ)
            reads_in++;
        else
            writes_in++;
    endtask

    task automatic access(input logic op, input logic [AW-1:0] addr,
                          input logic [DW-1:0] d);
        jfcd_pkg::in_item_t a;
        a.op      = op;
        a.address = addr;
        a.data    = d;
        offer(a);
    endtask

    // half the time a small pool of addresses so reads find programmed bytes
    function automatic logic [AW-1:0] any_addr();
        logic [AW-1:0] ad;
        ad = AW'($urandom);
        if ($urandom_range(0, 1))
            ad = hot_addr[$urandom_range(0, 15)];
        return ad;
    endfunction

    // occasional read in the middle of a command sequence
    task automatic maybe_peek();
        if ($urandom_range(0, 6) == 0)
            access(jfcd_pkg::OP_READ, any_addr(), DW'($urandom));
    endtask

    // unlock pair plus command byte; 'spoil' names the write to corrupt, or -1
    task automatic unlock_cmd(input logic [DW-1:0] cmd, input int spoil);
        logic [jfcd_pkg::CMD_ADDR_W-1:0] lo [3];
        logic [DW-1:0]                   by [3];
        logic [AW-1:0]                   ad;
        int                              k;
        int                              bit_no;
        lo = '{jfcd_pkg::ADDR_A, jfcd_pkg::ADDR_B, jfcd_pkg::ADDR_A};
        by = '{jfcd_pkg::BYTE_UNLOCK1, jfcd_pkg::BYTE_UNLOCK2, cmd};
        for (k = 0; k < 3; k++)
        begin
            // upper address bits do not take part in command decoding
            ad = AW'($urandom);
            if ($urandom_range(0, 1))
                ad[AW-1:jfcd_pkg::CMD_ADDR_W] = '0;
            ad[jfcd_pkg::CMD_ADDR_W-1:0] = lo[k];
            if (k == spoil)
            begin
                if ($urandom_range(0, 1))
                begin
                    bit_no = $urandom_range(0, jfcd_pkg::CMD_ADDR_W - 1);
                    ad[bit_no] = ~ad[bit_no];
                end
                else
                begin
                    bit_no = $urandom_range(0, DW - 1);
                    by[k][bit_no] = ~by[k][bit_no];
                end
            end
            access(jfcd_pkg::OP_WRITE, ad, by[k]);
            if (k < 2)
                maybe_peek();
        end
    endtask

    // stop offering and wait until every owed result has been popped
    task automatic drain();
        @(negedge clk);
        push <= 1'b0;
        while (access_results_due.size() != 0 || full)
            @(posedge clk);
    endtask

    // id bytes are only changed with the block idle
    task automatic load_ids(input logic [DW-1:0] m, input logic [DW-1:0] d);
        drain();
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= jfcd_pkg::CFG_MANUFACTURER_ID;
        cfg_data  <= m;
        @(posedge clk);
        mfr_id = m;
        @(negedge clk);
        cfg_index <= jfcd_pkg::CFG_DEVICE_ID;
        cfg_data  <= d;
        @(posedge clk);
        dev_id = d;
        @(negedge clk);
        cfg_write <= 1'b0;
        id_settings++;
    endtask

    function automatic dir_row_t row(input logic op, input logic [AW-1:0] addr,
                                     input logic [DW-1:0] d, input bit typed = 1'b0,
                                     input logic [DW-1:0] rd = '0,
                                     input logic idm = 1'b0);
        dir_row_t r;
        r.req.op             = op;
        r.req.address        = addr;
        r.req.data           = d;
        r.typed              = typed;
        r.want.read_data     = rd;
        r.want.in_id_mode    = idm;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result side: stall patterns change every stretch; one long hold-off
    // lets both internal queues fill so that full pushes back on requests
    // ------------------------------------------------------------------
    initial
    begin
        int         stretch_left;
        int         mode;
        int         hold_left;
        logic [7:0] pat;
        logic       ready;
        pop          = 1'b0;
        stretch_left = 0;
        mode         = 0;
        hold_left    = 0;
        pat          = 8'hFF;
        forever
        begin
            @(negedge clk);
            if (stretch_left == 0)
            begin
                stretch_left = $urandom_range(20, 160);
                mode         = $urandom_range(0, 3);
                pat          = 8'($urandom);
            end
            stretch_left--;
            pat = {pat[6:0], pat[7]};
            if (hold_off_req && !hold_off_done)
            begin
                hold_left     = HOLD_CYCLES;
                hold_off_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                ready = 1'b0;
            end
            else
            begin
                case (mode)
                    0:       ready = 1'b1;                        // no stalls
                    1:       ready = 1'($urandom_range(0, 1));
                    2:       ready = pat[0];                      // rotating pattern
                    default: ready = ($urandom_range(0, 3) == 0); // mostly stalled
                endcase
            end
            pop <= ready;
            @(posedge clk);
            if (pop && !empty)
                check_result(result);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still owed", cycle_count,
                     access_results_due.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int            i;
        int            phase;
        int            target;
        int            kind;
        int            random_done;
        dir_row_t      r;
        logic [DW-1:0] noise_bytes [8];

        rst_n     = 1'b0;
        push      = 1'b0;
        request   = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;

        noise_bytes = '{jfcd_pkg::BYTE_UNLOCK1, jfcd_pkg::BYTE_UNLOCK2,
                        jfcd_pkg::BYTE_ID_ENTRY, jfcd_pkg::BYTE_ID_EXIT,
                        jfcd_pkg::BYTE_PROGRAM, jfcd_pkg::BYTE_ERASE_SETUP,
                        jfcd_pkg::BYTE_CHIP_ERASE, jfcd_pkg::BYTE_ERASED};
        hot_addr[0] = '0;
        hot_addr[1] = '1;
        hot_addr[2] = {3'b000, jfcd_pkg::ADDR_A};
        hot_addr[3] = {3'b000, jfcd_pkg::ADDR_B};
        for (i = 4; i < 16; i++)
            hot_addr[i] = AW'($urandom);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table; the first request waits out the post-reset sweep
        plan.push_back(row(jfcd_pkg::OP_READ,  '0, 8'hFF, 1'b1, jfcd_pkg::BYTE_ERASED, 1'b0));
        plan.push_back(row(jfcd_pkg::OP_READ,  '1, 8'h00, 1'b1, jfcd_pkg::BYTE_ERASED, 1'b0));
        // enter id mode, read both id bytes at the address extremes
        plan.push_back(row(jfcd_pkg::OP_WRITE, {3'b000, jfcd_pkg::ADDR_A},
                           jfcd_pkg::BYTE_UNLOCK1));
        plan.push_back(row(jfcd_pkg::OP_WRITE, {3'b000, jfcd_pkg::ADDR_B},
                           jfcd_pkg::BYTE_UNLOCK2));
        plan.push_back(row(jfcd_pkg::OP_WRITE, {3'b000, jfcd_pkg::ADDR_A},
                           jfcd_pkg::BYTE_ID_ENTRY, 1'b1, 8'h00, 1'b1));
        plan.push_back(row(jfcd_pkg::OP_READ,  '0, 8'h00, 1'b1,
                           jfcd_pkg::MANUFACTURER_ID_RST, 1'b1));
        plan.push_back(row(jfcd_pkg::OP_READ,  '1, 8'hFF, 1'b1,
                           jfcd_pkg::DEVICE_ID_RST, 1'b1));
        // program while in id mode: cell changes, id mode stays
        plan.push_back(row(jfcd_pkg::OP_WRITE, {3'b000, jfcd_pkg::ADDR_A},
                           jfcd_pkg::BYTE_UNLOCK1));
        plan.push_back(row(jfcd_pkg::OP_WRITE, {3'b000, jfcd_pkg::ADDR_B},
                           jfcd_pkg::BYTE_UNLOCK2));
        plan.push_back(row(jfcd_pkg::OP_WRITE, {3'b000, jfcd_pkg::ADDR_A},
                           jfcd_pkg::BYTE_PROGRAM));
        plan.push_back(row(jfcd_pkg::OP_WRITE, '1, 8'h00, 1'b1, 8'h00, 1'b1));
        // short id exit at an unrelated address, then see the programmed byte
        plan.push_back(row(jfcd_pkg::OP_WRITE, 18'h12345, jfcd_pkg::BYTE_ID_EXIT,
                           1'b1, 8'h00, 1'b0));
        plan.push_back(row(jfcd_pkg::OP_READ,  '1, 8'h5A, 1'b1, 8'h00, 1'b0));
        // aliased command address, a read mid-sequence, unknown command byte
        plan.push_back(row(jfcd_pkg::OP_WRITE, {3'b111, jfcd_pkg::ADDR_A},
                           jfcd_pkg::BYTE_UNLOCK1));
        plan.push_back(row(jfcd_pkg::OP_READ,  18'h00001, 8'hA5, 1'b1,
                           jfcd_pkg::BYTE_ERASED, 1'b0));
        plan.push_back(row(jfcd_pkg::OP_WRITE, {3'b101, jfcd_pkg::ADDR_B},
                           jfcd_pkg::BYTE_UNLOCK2));
        plan.push_back(row(jfcd_pkg::OP_WRITE, {3'b000, jfcd_pkg::ADDR_A}, 8'h33));
        // broken sequence: second unlock at the wrong address
        plan.push_back(row(jfcd_pkg::OP_WRITE, {3'b000, jfcd_pkg::ADDR_A},
                           jfcd_pkg::BYTE_UNLOCK1));
        plan.push_back(row(jfcd_pkg::OP_WRITE, {3'b000, jfcd_pkg::ADDR_B} + 18'd1,
                           jfcd_pkg::BYTE_UNLOCK2));
        // full chip erase, then the programmed byte reads erased again
        plan.push_back(row(jfcd_pkg::OP_WRITE, {3'b000, jfcd_pkg::ADDR_A},
                           jfcd_pkg::BYTE_UNLOCK1));
        plan.push_back(row(jfcd_pkg::OP_WRITE, {3'b000, jfcd_pkg::ADDR_B},
                           jfcd_pkg::BYTE_UNLOCK2));
        plan.push_back(row(jfcd_pkg::OP_WRITE, {3'b000, jfcd_pkg::ADDR_A},
                           jfcd_pkg::BYTE_ERASE_SETUP));
        plan.push_back(row(jfcd_pkg::OP_WRITE, {3'b000, jfcd_pkg::ADDR_A},
                           jfcd_pkg::BYTE_UNLOCK1));
        plan.push_back(row(jfcd_pkg::OP_WRITE, {3'b000, jfcd_pkg::ADDR_B},
                           jfcd_pkg::BYTE_UNLOCK2));
        plan.push_back(row(jfcd_pkg::OP_WRITE, {3'b000, jfcd_pkg::ADDR_A},
                           jfcd_pkg::BYTE_CHIP_ERASE));
        plan.push_back(row(jfcd_pkg::OP_READ,  '1, 8'h00, 1'b1, jfcd_pkg::BYTE_ERASED, 1'b0));

        foreach (plan[k])
        begin
            r = plan[k];
            offer(r.req, r.typed, r.want);
        end

        // random traffic in phases, each with its own id bytes
        random_done = 0;
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       load_ids(8'h00, 8'hFF);
                1:       load_ids(8'hFF, 8'h00);
                default: load_ids(DW'($urandom), DW'($urandom));
            endcase
            target = accesses_in + PHASE_ITEMS;
            while (accesses_in < target)
            begin
                if (accesses_in - plan.size() > 600)
                    hold_off_req = 1'b1;
                kind = $urandom_range(0, 99);
                if (kind < 25)
                    access(jfcd_pkg::OP_READ, any_addr(), DW'($urandom));
                else if (kind < 50)
                begin
                    unlock_cmd(jfcd_pkg::BYTE_PROGRAM, -1);
                    maybe_peek();
                    access(jfcd_pkg::OP_WRITE, any_addr(),
                           ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom | $urandom));
                end
                else if (kind < 60)
                    unlock_cmd(jfcd_pkg::BYTE_ID_ENTRY, -1);
                else if (kind < 68)
                    unlock_cmd(jfcd_pkg::BYTE_ID_EXIT, -1);
                else if (kind < 73)
                    access(jfcd_pkg::OP_WRITE, any_addr(), jfcd_pkg::BYTE_ID_EXIT);
                else if (kind < 79)
                begin
                    // erase, unless the budget is spent or a write is spoiled (then it ends up broken)
                    unlock_cmd(jfcd_pkg::BYTE_ERASE_SETUP, -1);
                    unlock_cmd(jfcd_pkg::BYTE_CHIP_ERASE, ($urandom_range(0, 2) == 0) ?
                               int'($urandom_range(0, 2)) : -1);
                end
                else if (kind < 92)
                    unlock_cmd(noise_bytes[$urandom_range(0, 6)],
                               int'($urandom_range(0, 2)));
                else
                    access(jfcd_pkg::OP_WRITE, AW'($urandom), $urandom_range(0, 1) ?
                           noise_bytes[$urandom_range(0, 7)] : 8'($urandom));
            end
            random_done = accesses_in - plan.size();
        end

        drain();
        repeat (SETTLE) @(posedge clk);
        if (access_results_due.size() != 0)
            report("results never delivered", access_results_due.size(), 0);

        $display("%0d accesses (%0d random): %0d reads, %0d writes, %0d programs, %0d id entries",
                 accesses_in, random_done, reads_in, writes_in, programs_seen, id_entries);
        $display("%0d chip erases, %0d id settings, %0d results checked, %0d cycles held on full",
                 erases_seen, id_settings, results_checked, full_stall_cycles);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
